/* sv/eeg_pkg.sv */
package eeg_pkg;
  localparam int unsigned OPERAND_WIDTH_DEF = 32;
endpackage

/* sv/eeg_divider.sv */
// restoring divider, one quotient bit per cycle
module eeg_divider import eeg_pkg::*; #(
  parameter int unsigned W = OPERAND_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[W-1]};
    diff     = trial - {1'b0, dvs_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule

/* sv/eeg_mulsub.sv */
// next = prev - q*cur, shift-and-add over q one bit per cycle, mod 2^(W+1)
module eeg_mulsub import eeg_pkg::*; #(
  parameter int unsigned W = OPERAND_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] q,
  input  logic [W:0]   prev_a,
  input  logic [W:0]   cur_a,
  input  logic [W:0]   prev_b,
  input  logic [W:0]   cur_b,
  output logic         done,
  output logic [W:0]   next_a,
  output logic [W:0]   next_b
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W:0]    acc_a_r, acc_a_nxt, acc_b_r, acc_b_nxt;
  logic [W:0]    sh_a_r, sh_a_nxt, sh_b_r, sh_b_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    q_nxt     = q_r;
    acc_a_nxt = acc_a_r;
    acc_b_nxt = acc_b_r;
    sh_a_nxt  = sh_a_r;
    sh_b_nxt  = sh_b_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      q_nxt     = q;
      acc_a_nxt = prev_a;
      acc_b_nxt = prev_b;
      sh_a_nxt  = cur_a;
      sh_b_nxt  = cur_b;
      cnt_nxt   = CW'(W);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      if (q_r[0]) begin
        acc_a_nxt = acc_a_r - sh_a_r;
        acc_b_nxt = acc_b_r - sh_b_r;
      end
      q_nxt    = q_r >> 1;
      sh_a_nxt = sh_a_r << 1;
      sh_b_nxt = sh_b_r << 1;
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r     <= q_nxt;
    acc_a_r <= acc_a_nxt;
    acc_b_r <= acc_b_nxt;
    sh_a_r  <= sh_a_nxt;
    sh_b_r  <= sh_b_nxt;
    cnt_r   <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done   = done_r;
  assign next_a = acc_a_r;
  assign next_b = acc_b_r;
endmodule

/* sv/extended_euclid_gcd_core.sv */
// extended euclid: gcd and bezout coefficients of two unsigned operands
// a zero operand takes no quotient step; each other quotient step runs
// a bit-serial divider then a bit-serial multiply-subtract, ~46 steps worst at W=32
// throughput: one transaction at a time; the next input is taken once the run is done,
// while the previous result may still wait in the output register
// reset: synchronous active-low rst_n clears the sequencer and the output valid
module extended_euclid_gcd_core import eeg_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0]     in_tdata,  // operand_a, operand_b
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [((3*OPERAND_WIDTH+9)/8)*8-1:0]     out_tdata  // gcd_value, coeff_a, coeff_b
);
  localparam int unsigned W      = OPERAND_WIDTH;
  localparam int unsigned OUT_TW = ((3*OPERAND_WIDTH+9)/8)*8;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]   state_r, state_nxt;
  logic [W-1:0] big_r, big_nxt, small_r, small_nxt;
  logic [W:0]   bp_r, bp_nxt, bc_r, bc_nxt, sp_r, sp_nxt, sc_r, sc_nxt;
  logic         xchg_r, xchg_nxt;
  logic         ovalid_r, ovalid_nxt;
  logic [3*W+1:0] odata_r, odata_nxt;
  logic [W-1:0] rem_hold_r, rem_hold_nxt;

  logic         div_start, div_done, mul_start, mul_done;
  logic [W-1:0] div_q, div_rem;
  logic [W:0]   nx_a, nx_b;
  logic [W-1:0] op_a, op_b;

  assign op_a = in_tdata[W-1:0];
  assign op_b = in_tdata[2*W-1:W];

  // input taken whenever idle; a finished result waits in the output register
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    big_nxt      = big_r;
    small_nxt    = small_r;
    bp_nxt       = bp_r;
    bc_nxt       = bc_r;
    sp_nxt       = sp_r;
    sc_nxt       = sc_r;
    xchg_nxt     = xchg_r;
    rem_hold_nxt = rem_hold_r;
    ovalid_nxt   = ovalid_r;
    odata_nxt    = odata_r;
    div_start    = 1'b0;
    mul_start    = 1'b0;
    if (out_tvalid && out_tready) ovalid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          xchg_nxt  = op_a < op_b;
          big_nxt   = (op_a < op_b) ? op_b : op_a;
          small_nxt = (op_a < op_b) ? op_a : op_b;
          bp_nxt    = (W+1)'(1);
          bc_nxt    = '0;
          sp_nxt    = '0;
          sc_nxt    = (W+1)'(1);
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // loop test: remainder zero ends the run
        if (small_r == '0) begin
          // wait until the output register is free or freed this cycle
          if (!ovalid_nxt) begin
            odata_nxt  = xchg_r ? {bp_r, sp_r, big_r} : {sp_r, bp_r, big_r};
            ovalid_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mul_start    = 1'b1;
          rem_hold_nxt = div_rem;
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          big_nxt   = small_r;
          small_nxt = rem_hold_r;
          bp_nxt    = bc_r;
          bc_nxt    = nx_a;
          sp_nxt    = sc_r;
          sc_nxt    = nx_b;
          state_nxt = ST_FIN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  eeg_divider #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(big_r), .divisor(small_r),
    .done(div_done), .quotient(div_q), .remainder(div_rem)
  );

  eeg_mulsub #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .q(div_q),
    .prev_a(bp_r), .cur_a(bc_r), .prev_b(sp_r), .cur_b(sc_r),
    .done(mul_done), .next_a(nx_a), .next_b(nx_b)
  );

  always_ff @(posedge clk) begin
    big_r      <= big_nxt;
    small_r    <= small_nxt;
    bp_r       <= bp_nxt;
    bc_r       <= bc_nxt;
    sp_r       <= sp_nxt;
    sc_r       <= sc_nxt;
    xchg_r     <= xchg_nxt;
    rem_hold_r <= rem_hold_nxt;
    odata_r    <= odata_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  // upper pad bits are zero
  assign out_tdata  = OUT_TW'(odata_r);

  // output register holds while stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_tready |=> ovalid_r && $stable(odata_r))
    else $error("result changed under stall");
  // divider only runs with a nonzero divisor
  assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> small_r != '0)
    else $error("division by zero started");
  // no input accepted while a run is active
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_tready)
    else $error("input accepted mid run");
endmodule
